### sv/controller_side_command_responder_macros.svh
// Assertion macros used by the responder top level.
`ifndef CONTROLLER_SIDE_COMMAND_RESPONDER_MACROS_SVH
`define CONTROLLER_SIDE_COMMAND_RESPONDER_MACROS_SVH
`ifndef SYNTH
`define CRSP_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("crsp: same-cycle check failed");
`define CRSP_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("crsp: next-cycle check failed");
`else
`define CRSP_ASSERT_IMP(label, ck, rn, ante, cons)
`define CRSP_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

### sv/crsp_pkg.sv
// Types, codes and reply byte helpers for the command responder.
package crsp_pkg;

  typedef logic [59:0] report_t;
  typedef logic [1:0]  kind_t;

  localparam kind_t KIND_PROBE  = 2'd0;
  localparam kind_t KIND_ORIGIN = 2'd1;
  localparam kind_t KIND_POLL   = 2'd2;

  localparam logic [7:0] CMD_PROBE  = 8'h00;
  localparam logic [7:0] CMD_RESET  = 8'hFF;
  localparam logic [7:0] CMD_ORIGIN = 8'h41;
  localparam logic [7:0] CMD_RECAL  = 8'h42;
  localparam logic [7:0] CMD_POLL   = 8'h40;
  localparam logic [7:0] POLL_MODE  = 8'h03;

  localparam logic [7:0] PROBE_B0 = 8'h09;
  localparam logic [7:0] PROBE_B1 = 8'h00;
  localparam logic [7:0] PROBE_B2 = 8'h03;

  localparam logic [4:0] SHORT_CELLS = 5'd9;
  localparam logic [4:0] LONG_CELLS  = 5'd25;
  localparam logic [4:0] CELL_SAT    = 5'd31;
  localparam logic [4:0] CMD_CELLS   = 5'd16;

  localparam logic [3:0] PROBE_LAST_IDX  = 4'd2;
  localparam logic [3:0] POLL_LAST_IDX   = 4'd7;
  localparam logic [3:0] ORIGIN_LAST_IDX = 4'd9;

  // reply job queue between front and back
  localparam int JQ_DEPTH = 2;

  typedef struct packed {
    logic        func;
    logic [14:0] low_ticks;
    logic [14:0] high_ticks;
    logic        frame_end;
    logic [11:0] buttons;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  cstick_x;
    logic [7:0]  cstick_y;
    logic [7:0]  left_analog;
    logic [7:0]  right_analog;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    kind_t      reply_kind;
    logic       last;
  } out_word_t;

  typedef struct packed {
    kind_t   kind;
    report_t report;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } jq_stat_t;

  function automatic report_t pack_report(in_word_t w);
    return {w.right_analog, w.left_analog, w.cstick_y, w.cstick_x,
            w.stick_y, w.stick_x, w.buttons};
  endfunction

  function automatic logic [3:0] last_index(kind_t k);
    logic [3:0] idx;
    unique case (k)
      KIND_PROBE:  idx = PROBE_LAST_IDX;
      KIND_ORIGIN: idx = ORIGIN_LAST_IDX;
      default:     idx = POLL_LAST_IDX;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] reply_byte_at(kind_t k, report_t r, logic [3:0] idx);
    logic [7:0] b;
    if (k == KIND_PROBE) begin
      unique case (idx)
        4'd0:    b = PROBE_B0;
        4'd1:    b = PROBE_B1;
        default: b = PROBE_B2;
      endcase
    end else begin
      unique case (idx)
        4'd0:    b = {3'b000, r[0], r[1], r[2], r[3], r[4]};
        4'd1:    b = {1'b1, r[5], r[6], r[7], r[8], r[9], r[10], r[11]};
        4'd2:    b = r[19:12];
        4'd3:    b = r[27:20];
        4'd4:    b = r[35:28];
        4'd5:    b = r[43:36];
        4'd6:    b = r[51:44];
        4'd7:    b = r[59:52];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

### sv/controller_side_command_responder.sv
// Controller-side command responder: takes line cells and controller reports, sends reply words.
//
// Input words are either received line cells (func = 0) or fresh controller reports
// (func = 1); one word is taken per clock while full is low. A cell counts as a one when
// its low time is shorter than its high time. Reports land in a REPORT_QUEUE_DEPTH-entry
// FIFO that drops new reports when full. A cell with frame_end closes the frame: a 9-cell
// 0x00/0xFF frame gives the probe reply 09 00 03 and latches the newest report (emptying
// the FIFO), a 9-cell 0x41/0x42 frame clears the latched buttons and gives the 10-word
// origin reply, a 25-cell 0x40 0x03 frame pops one report into the latch and gives the
// 8-word poll reply. Other frames give no reply. Result words come out one per clock while
// empty is low, oldest first, with last set on the final word of each reply.
// Flow: the front end takes a word every clock while full is low. A reply-causing frame passes
// through a second front-end stage (registered read of the report RAM); its first reply word
// goes through the job queue into the output register. After that the byte sequencer delivers
// one word per clock as long as pop stays high. A two-entry reply job queue sits between the
// two sides; full rises while that queue is full, or holds one reply while another waits in
// the second stage, so a stalled consumer holds the input off once two replies are pending.
// No clearing pass after reset: the report RAM is only read at entries written since reset.
`include "controller_side_command_responder_macros.svh"

module controller_side_command_responder
  import crsp_pkg::*;
#(
  parameter int REPORT_QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  // input word channel
  input  logic      push,
  output logic      full,
  input  in_word_t  in_data,
  // result word channel
  input  logic      pop,
  output logic      empty,
  output out_word_t out_data
);

  // front end -> job queue
  logic     job_push;
  job_t     job;
  // job queue -> back end
  job_t     jq_job;
  logic     jq_pop;
  jq_stat_t jq_stat;

  // cell decode, frame classification, report FIFO and latch
  crsp_front #(
    .DEPTH (REPORT_QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .jq_stat  (jq_stat),
    .full     (full),
    .job_push (job_push),
    .job      (job)
  );

  // decouples frame decode from reply delivery; each job carries a snapshot of the
  // latched report so later frames cannot disturb a reply still going out
  crsp_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job),
    .rd_en  (jq_pop),
    .rd_job (jq_job),
    .stat   (jq_stat)
  );

  // turns jobs into reply words, one per clock as long as pop stays high
  crsp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .jq_empty (jq_stat.empty),
    .jq_job   (jq_job),
    .jq_pop   (jq_pop),
    .pop      (pop & ~empty),
    .empty    (empty),
    .out_data (out_data)
  );

  // front end must never push into a full job queue
  `CRSP_ASSERT_IMP(a_jq_room, clk, rst_n, job_push, !jq_stat.full)
  // replying frames are at least nine cells apart, so jobs never come back to back
  `CRSP_ASSERT_NXT(a_job_spacing, clk, rst_n, job_push, !job_push)
  // a probe reply always closes on its fixed third word
  `CRSP_ASSERT_IMP(a_probe_tail, clk, rst_n, !empty && out_data.reply_kind == KIND_PROBE && out_data.last, out_data.reply_byte == PROBE_B2)

endmodule

### sv/crsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crsp_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/crsp_front.sv
// Front end: cell decode, frame classification, report FIFO and latched report.
module crsp_front
  import crsp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_word_t in_data,
  input  jq_stat_t jq_stat,
  output logic     full,
  output logic     job_push,
  output job_t     job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

  logic [4:0]    cell_count_r, cell_count_nxt;
  logic [15:0]   command_bits_r, command_bits_nxt;
  report_t       latch_r, latch_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          s2_valid_r, s2_load_r;
  kind_t         s2_kind_r, s2_kind_nxt;

  logic          accept, cell_acc, rep_acc, frame_acc, cell_bit;
  logic [15:0]   cb_shift;
  logic [4:0]    cc_inc;
  logic [7:0]    short_cmd;
  logic          is_probe, is_origin, is_poll, have_rep;
  logic          wr_en, rd_en;
  logic [AW-1:0] newest, rd_addr;
  report_t       ram_q;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign full   = jq_stat.full | (jq_stat.afull & s2_valid_r);
  assign accept = push & ~full;

  assign cell_acc  = accept & ~in_data.func;
  assign rep_acc   = accept & in_data.func;
  assign frame_acc = cell_acc & in_data.frame_end;

  assign cell_bit  = in_data.low_ticks < in_data.high_ticks;
  assign cb_shift  = (cell_count_r < CMD_CELLS) ? {command_bits_r[14:0], cell_bit}
                                                : command_bits_r;
  assign cc_inc    = (cell_count_r != CELL_SAT) ? cell_count_r + 5'd1 : cell_count_r;
  assign short_cmd = cb_shift[8:1];

  assign is_probe  = frame_acc && (cc_inc == SHORT_CELLS) &&
                     ((short_cmd == CMD_PROBE) || (short_cmd == CMD_RESET));
  assign is_origin = frame_acc && (cc_inc == SHORT_CELLS) &&
                     ((short_cmd == CMD_ORIGIN) || (short_cmd == CMD_RECAL));
  assign is_poll   = frame_acc && (cc_inc == LONG_CELLS) &&
                     (cb_shift[15:8] == CMD_POLL) && (cb_shift[7:0] == POLL_MODE);

  assign have_rep = fill_r != '0;
  assign newest   = (tail_r == '0) ? LAST_PTR : tail_r - 1'b1;
  assign wr_en    = rep_acc && (fill_r < FILL_MAX);
  assign rd_en    = (is_probe | is_poll) & have_rep;
  assign rd_addr  = is_probe ? newest : head_r;

  crsp_ram #(
    .WIDTH ($bits(report_t)),
    .DEPTH (DEPTH)
  ) u_report_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (pack_report(in_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    cell_count_nxt   = cell_count_r;
    command_bits_nxt = command_bits_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    fill_nxt         = fill_r;
    if (cell_acc) begin
      if (in_data.frame_end) begin
        cell_count_nxt   = '0;
        command_bits_nxt = '0;
      end else begin
        cell_count_nxt   = cc_inc;
        command_bits_nxt = cb_shift;
      end
    end
    if (wr_en) begin
      tail_nxt = wrap_inc(tail_r);
      fill_nxt = fill_r + 1'b1;
    end
    if (is_probe && have_rep) begin
      head_nxt = tail_r;
      fill_nxt = '0;
    end
    if (is_poll && have_rep) begin
      head_nxt = wrap_inc(head_r);
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_comb begin
    if (is_probe) begin
      s2_kind_nxt = KIND_PROBE;
    end else if (is_origin) begin
      s2_kind_nxt = KIND_ORIGIN;
    end else begin
      s2_kind_nxt = KIND_POLL;
    end
  end

  // stage 2: the report RAM data is here, update the latch and issue the job
  always_comb begin
    latch_nxt = s2_load_r ? ram_q : latch_r;
    if (s2_kind_r == KIND_ORIGIN) begin
      latch_nxt[11:0] = '0;
    end
  end

  assign job_push   = s2_valid_r;
  assign job.kind   = s2_kind_r;
  assign job.report = latch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r   <= '0;
      command_bits_r <= '0;
      latch_r        <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      fill_r         <= '0;
      s2_valid_r     <= 1'b0;
      s2_load_r      <= 1'b0;
      s2_kind_r      <= KIND_PROBE;
    end else begin
      cell_count_r   <= cell_count_nxt;
      command_bits_r <= command_bits_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      fill_r         <= fill_nxt;
      s2_valid_r     <= is_probe | is_origin | is_poll;
      s2_load_r      <= rd_en;
      s2_kind_r      <= s2_kind_nxt;
      if (s2_valid_r) begin
        latch_r <= latch_nxt;
      end
    end
  end

endmodule

### sv/crsp_jobq.sv
// Short reply job queue between the front end and the byte sequencer.
module crsp_jobq
  import crsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  job_t     wr_job,
  input  logic     rd_en,
  output job_t     rd_job,
  output jq_stat_t stat
);

  localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int CW = $clog2(JQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(JQ_DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(JQ_DEPTH);
  localparam logic [CW-1:0] CNT_HIGH = CW'(JQ_DEPTH - 1);

  job_t          mem_r [JQ_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign rd_job     = mem_r[rptr_r];
  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == CNT_MAX;
  assign stat.afull = count_r >= CNT_HIGH;

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
      end
    end
  end

endmodule

### sv/crsp_back.sv
// Back end: walks the head job byte by byte into the output register.
module crsp_back
  import crsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      jq_empty,
  input  job_t      jq_job,
  output logic      jq_pop,
  input  logic      pop,
  output logic      empty,
  output out_word_t out_data
);

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  logic       load, take, is_last;

  assign load    = ~out_valid_r | pop;
  assign take    = load & ~jq_empty;
  assign is_last = idx_r == last_index(jq_job.kind);
  assign jq_pop  = take & is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & ~pop;
    if (take) begin
      idx_nxt       = is_last ? 4'd0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r.reply_byte <= reply_byte_at(jq_job.kind, jq_job.report, idx_r);
      out_word_r.reply_kind <= jq_job.kind;
      out_word_r.last       <= is_last;
    end
  end

  assign empty    = ~out_valid_r;
  assign out_data = out_word_r;

endmodule
